/* hdl/assert_macros.svh */
// Assertion macros for the RTL file that carries checks.
// Depends on a clock named clk and a synchronous active-high reset named rst.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at each rising clock edge, masked while reset is high.
`define ASSERT_CLK(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property at each rising clock edge, reset included.
`define ASSERT_CLK_ANY(name, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hdl/lse_pkg.sv */
// Shared types, codes and defaults of the LSB stego payload extractor.
// No dependencies; imported by every module of the block except lse_queue.
package lse_pkg;

  // Sizing defaults
  localparam int LSE_MAGIC_MAX    = 8;
  localparam int LSE_TOKEN_DEPTH  = 4;
  localparam int LSE_RESULT_DEPTH = 2;

  // Register reset values
  localparam logic [7:0]  HEADER_BYTES_RST = 8'd54;
  localparam logic [3:0]  MAGIC_LEN_RST    = 4'd1;
  localparam logic [63:0] MAGIC_CHARS_RST  = 64'd0;
  localparam logic [7:0]  EXT_LIMIT_RST    = 8'd16;

  // Configuration register indexes
  localparam logic [1:0] CFG_HEADER_BYTES = 2'd0;
  localparam logic [1:0] CFG_MAGIC_LEN    = 2'd1;
  localparam logic [1:0] CFG_MAGIC_CHARS  = 2'd2;
  localparam logic [1:0] CFG_EXT_LIMIT    = 2'd3;

  // Result kinds
  localparam logic [2:0] KIND_EXT      = 3'd0;
  localparam logic [2:0] KIND_DATA     = 3'd1;
  localparam logic [2:0] KIND_BADMAGIC = 3'd2;
  localparam logic [2:0] KIND_EXTLONG  = 3'd3;
  localparam logic [2:0] KIND_EMPTY    = 3'd4;

  // One classified image byte handed from the front to the back
  typedef struct packed {
    logic restart;  // first byte of a new image
    logic is_bit;   // byte lies past the header and carries a hidden bit
    logic bit_val;  // bit 0 of the byte
  } token_t;

  // One result request
  typedef struct packed {
    logic [7:0] out_byte;
    logic [2:0] out_kind;
    logic       out_last;
  } result_t;

endpackage

/* hdl/lse_queue.sv */
// Small first-in first-out queue with a register-array store.
// No package dependencies; used for the token and result queues.
module lse_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             full,
  output logic             empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_PTR  = AW'(DEPTH - 1);
  localparam logic [CW-1:0] DEPTH_CNT = CW'(DEPTH);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == DEPTH_CNT);
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  // Store the pushed request
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  // Advance pointers and track the fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

/* hdl/lse_front.sv */
// Front end: accepts image bytes, skips the header and classifies each byte.
// Depends on lse_pkg for the token type.
module lse_front import lse_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic [7:0] pixel_byte,
  input  logic       start_of_file,
  input  logic [7:0] header_bytes,
  output logic       tok_push,
  output token_t     tok
);

  logic       in_hdr;
  logic [7:0] hdr_count;
  logic       in_hdr_next;
  logic [7:0] hdr_count_next;
  logic       cur_in_hdr;
  logic [7:0] cur_count;
  logic       skip;

  // Restart the header count on a start flag, then test the byte
  always_comb begin
    cur_in_hdr = start_of_file ? 1'b1 : in_hdr;
    cur_count  = start_of_file ? 8'd0 : hdr_count;
    skip       = cur_in_hdr && (cur_count < header_bytes);
    in_hdr_next    = skip;
    hdr_count_next = skip ? cur_count + 8'd1 : cur_count;
  end

  // Forward hidden bits and restarts; drop plain header bytes
  assign tok.restart = start_of_file;
  assign tok.is_bit  = !skip;
  assign tok.bit_val = pixel_byte[0];
  assign tok_push    = accept && (start_of_file || !skip);

  always_ff @(posedge clk) begin
    if (rst) begin
      in_hdr    <= 1'b1;
      hdr_count <= 8'd0;
    end else if (accept) begin
      in_hdr    <= in_hdr_next;
      hdr_count <= hdr_count_next;
    end
  end

endmodule

/* hdl/lse_back.sv */
// Back end: gathers hidden bits into words and runs the parse sequence.
// Depends on lse_pkg for token and result types and result kinds.
module lse_back import lse_pkg::*; #(
  parameter int MAGIC_MAX = LSE_MAGIC_MAX
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        tok_valid,
  input  token_t      tok,
  input  logic        res_room,
  input  logic [3:0]  magic_len,
  input  logic [63:0] magic_chars,
  input  logic [7:0]  ext_limit,
  output logic        tok_pop,
  output logic        res_push,
  output result_t     res
);

  localparam int IW = (MAGIC_MAX > 1) ? $clog2(MAGIC_MAX) : 1;
  localparam logic [3:0] MAGIC_MAX_LEN = 4'(MAGIC_MAX);

  localparam logic [2:0] PH_MAGIC   = 3'd0;
  localparam logic [2:0] PH_EXTLEN  = 3'd1;
  localparam logic [2:0] PH_EXT     = 3'd2;
  localparam logic [2:0] PH_DATALEN = 3'd3;
  localparam logic [2:0] PH_DATA    = 3'd4;
  localparam logic [2:0] PH_IDLE    = 3'd5;

  logic [2:0]    phase, phase_next;
  logic [4:0]    bit_count, bit_count_next;
  logic [31:0]   bit_shift, bit_shift_next;
  logic [IW-1:0] magic_index, magic_index_next;
  logic          magic_bad, magic_bad_next;
  logic [31:0]   remaining, remaining_next;

  logic [4:0]  last_bit;
  logic [31:0] word;
  logic [3:0]  mlen;
  logic [7:0]  magic_sel;
  logic        emit;

  assign tok_pop  = tok_valid && res_room;
  assign res_push = tok_pop && emit;

  // Clamp the magic length to the supported range
  always_comb begin
    if (magic_len == 4'd0) begin
      mlen = 4'd1;
    end else if (magic_len > MAGIC_MAX_LEN) begin
      mlen = MAGIC_MAX_LEN;
    end else begin
      mlen = magic_len;
    end
  end

  // Step the parser for one token
  always_comb begin
    phase_next       = phase;
    bit_count_next   = bit_count;
    bit_shift_next   = bit_shift;
    magic_index_next = magic_index;
    magic_bad_next   = magic_bad;
    remaining_next   = remaining;
    emit             = 1'b0;
    res              = '0;

    if (tok.restart) begin
      phase_next       = PH_MAGIC;
      bit_count_next   = 5'd0;
      bit_shift_next   = 32'd0;
      magic_index_next = '0;
      magic_bad_next   = 1'b0;
      remaining_next   = 32'd0;
    end

    last_bit  = (phase_next inside {PH_EXTLEN, PH_DATALEN}) ? 5'd31 : 5'd7;
    word      = {bit_shift_next[30:0], tok.bit_val};
    magic_sel = magic_chars[{magic_index_next, 3'b000} +: 8];

    if (tok.is_bit && (phase_next != PH_IDLE)) begin
      if (bit_count_next != last_bit) begin
        // Keep gathering bits of the current word
        bit_count_next = bit_count_next + 5'd1;
        bit_shift_next = word;
      end else begin
        bit_count_next = 5'd0;
        bit_shift_next = 32'd0;
        case (phase_next)
          PH_MAGIC: begin
            if (word[7:0] != magic_sel) begin
              magic_bad_next = 1'b1;
            end
            if ((4'(magic_index_next) + 4'd1) >= mlen) begin
              magic_index_next = '0;
              if (magic_bad_next) begin
                phase_next   = PH_IDLE;
                emit         = 1'b1;
                res.out_kind = KIND_BADMAGIC;
                res.out_last = 1'b1;
              end else begin
                phase_next = PH_EXTLEN;
              end
            end else begin
              magic_index_next = magic_index_next + 1'b1;
            end
          end
          PH_EXTLEN: begin
            if (word > {24'd0, ext_limit}) begin
              phase_next   = PH_IDLE;
              emit         = 1'b1;
              res.out_kind = KIND_EXTLONG;
              res.out_last = 1'b1;
            end else begin
              remaining_next = word;
              phase_next     = (word == 32'd0) ? PH_DATALEN : PH_EXT;
            end
          end
          PH_EXT: begin
            remaining_next = remaining_next - 32'd1;
            if (remaining_next == 32'd0) begin
              phase_next = PH_DATALEN;
            end
            emit         = 1'b1;
            res.out_byte = word[7:0];
            res.out_kind = KIND_EXT;
          end
          PH_DATALEN: begin
            if (word == 32'd0) begin
              phase_next   = PH_IDLE;
              emit         = 1'b1;
              res.out_kind = KIND_EMPTY;
              res.out_last = 1'b1;
            end else begin
              remaining_next = word;
              phase_next     = PH_DATA;
            end
          end
          PH_DATA: begin
            remaining_next = remaining_next - 32'd1;
            emit           = 1'b1;
            res.out_byte   = word[7:0];
            res.out_kind   = KIND_DATA;
            if (remaining_next == 32'd0) begin
              phase_next   = PH_IDLE;
              res.out_last = 1'b1;
            end
          end
          default: begin
            phase_next = PH_IDLE;
          end
        endcase
      end
    end
  end

  // Commit parser state when a token is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_MAGIC;
      bit_count   <= 5'd0;
      bit_shift   <= 32'd0;
      magic_index <= '0;
      magic_bad   <= 1'b0;
      remaining   <= 32'd0;
    end else if (tok_pop) begin
      phase       <= phase_next;
      bit_count   <= bit_count_next;
      bit_shift   <= bit_shift_next;
      magic_index <= magic_index_next;
      magic_bad   <= magic_bad_next;
      remaining   <= remaining_next;
    end
  end

endmodule

/* hdl/lsb_stego_payload_extractor.sv */
// LSB stego payload extractor: one image byte per cycle in while not full,
// one result per cycle out while not empty. Each result passes through the token queue
// and the result queue; the parser takes one token per cycle while the result queue has room.
// Reset (rst, synchronous): registers take their defaults, both queues empty, and
// parsing restarts at the header as if a start flag had come.
// Depends on lse_pkg, lse_queue, lse_front, lse_back and assert_macros.svh.
`include "assert_macros.svh"

module lsb_stego_payload_extractor import lse_pkg::*; #(
  parameter int MAGIC_MAX    = LSE_MAGIC_MAX,
  parameter int TOKEN_DEPTH  = LSE_TOKEN_DEPTH,
  parameter int RESULT_DEPTH = LSE_RESULT_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  pixel_byte,
  input  logic        start_of_file,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  out_byte,
  output logic [2:0]  out_kind,
  output logic        out_last,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  logic [7:0]  header_bytes;
  logic [3:0]  magic_len;
  logic [63:0] magic_chars;
  logic [7:0]  ext_limit;

  logic    accept;
  logic    tok_push;
  token_t  tok_in;
  token_t  tok_out;
  logic    tok_full;
  logic    tok_empty;
  logic    tok_pop;
  logic    res_push;
  logic    res_full;
  result_t res_in;
  result_t res_out;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      header_bytes <= HEADER_BYTES_RST;
      magic_len    <= MAGIC_LEN_RST;
      magic_chars  <= MAGIC_CHARS_RST;
      ext_limit    <= EXT_LIMIT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_HEADER_BYTES: header_bytes <= cfg_data[7:0];
        CFG_MAGIC_LEN:    magic_len    <= cfg_data[3:0];
        CFG_MAGIC_CHARS:  magic_chars  <= cfg_data;
        CFG_EXT_LIMIT:    ext_limit    <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  assign full   = tok_full;
  assign accept = push && !tok_full;

  // Classify incoming bytes
  lse_front u_front (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .pixel_byte   (pixel_byte),
    .start_of_file(start_of_file),
    .header_bytes (header_bytes),
    .tok_push     (tok_push),
    .tok          (tok_in)
  );

  // Decouple the front from the parser
  lse_queue #(
    .WIDTH($bits(token_t)),
    .DEPTH(TOKEN_DEPTH)
  ) u_tok_queue (
    .clk  (clk),
    .rst  (rst),
    .push (tok_push),
    .wdata(tok_in),
    .pop  (tok_pop),
    .rdata(tok_out),
    .full (tok_full),
    .empty(tok_empty)
  );

  // Parse hidden bits into results
  lse_back #(
    .MAGIC_MAX(MAGIC_MAX)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .tok_valid  (!tok_empty),
    .tok        (tok_out),
    .res_room   (!res_full),
    .magic_len  (magic_len),
    .magic_chars(magic_chars),
    .ext_limit  (ext_limit),
    .tok_pop    (tok_pop),
    .res_push   (res_push),
    .res        (res_in)
  );

  // Hold results until the consumer takes them
  lse_queue #(
    .WIDTH($bits(result_t)),
    .DEPTH(RESULT_DEPTH)
  ) u_res_queue (
    .clk  (clk),
    .rst  (rst),
    .push (res_push),
    .wdata(res_in),
    .pop  (pop),
    .rdata(res_out),
    .full (res_full),
    .empty(empty)
  );

  assign out_byte = res_out.out_byte;
  assign out_kind = res_out.out_kind;
  assign out_last = res_out.out_last;

  `ASSERT_CLK_ANY(a_reset_empties, rst |=> empty, "result queue not empty after reset")
  `ASSERT_CLK(a_ext_not_last, (!empty && out_kind == KIND_EXT) |-> !out_last,
              "extension character marked last")
  `ASSERT_CLK(a_status_shape, (!empty && (out_kind == KIND_BADMAGIC ||
              out_kind == KIND_EXTLONG || out_kind == KIND_EMPTY)) |->
              (out_last && out_byte == 8'd0), "status result with data or without last")
  `ASSERT_CLK(a_no_drop, (tok_push && !tok_full) |-> accept,
              "token queued without an accepted byte")

endmodule

/* verif/lsb_stego_payload_extractor_tb.sv */
// Self-checking testbench for lsb_stego_payload_extractor: builds stego byte streams,
// predicts the decoded characters and status results, and compares every result popped.
// Depends on lse_pkg and the lsb_stego_payload_extractor RTL.
module lsb_stego_payload_extractor_tb import lse_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int RANDOM_ITEMS  = 200;
  localparam int RANDOM_RESULTS = 10;
  localparam int SETTLE_CYCLES = 16;
  localparam int PAYLOAD_CAP   = 16;
  localparam int MAX_PRINTS    = 50;

  typedef enum logic [2:0] {
    PH_HEADER, PH_MAGIC, PH_EXTLEN, PH_EXT, PH_DATALEN, PH_DATA, PH_IDLE
  } parse_phase_e;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic        full;
  logic [7:0]  pixel_byte = 8'd0;
  logic        start_of_file = 1'b0;
  logic        empty;
  logic        pop = 1'b0;
  logic [7:0]  out_byte;
  logic [2:0]  out_kind;
  logic        out_last;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = CFG_HEADER_BYTES;
  logic [63:0] cfg_data = 64'd0;

  lsb_stego_payload_extractor DUT (
    .clk(clk), .rst(rst),
    .push(push), .full(full), .pixel_byte(pixel_byte), .start_of_file(start_of_file),
    .empty(empty), .pop(pop), .out_byte(out_byte), .out_kind(out_kind),
    .out_last(out_last),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Clock: 2 ns period
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Register copies kept by the decoder prediction
  logic [7:0]  reg_header    = HEADER_BYTES_RST;
  logic [3:0]  reg_magic_len = MAGIC_LEN_RST;
  logic [63:0] reg_magic     = MAGIC_CHARS_RST;
  logic [7:0]  reg_ext_limit = EXT_LIMIT_RST;

  // Parse state of the decoder prediction
  parse_phase_e dec_phase    = PH_HEADER;
  logic [7:0]   dec_hdr_seen = 8'd0;
  logic [4:0]   dec_bit_cnt  = 5'd0;
  logic [31:0]  dec_shift    = 32'd0;
  logic [2:0]   dec_magic_at = 3'd0;
  logic         dec_magic_bad = 1'b0;
  logic [31:0]  dec_left     = 32'd0;

  result_t    decoded_q[$];
  logic [7:0] img_q[$];
  int         err_count = 0;
  int         items_sent = 0;
  int         results_due = 0;
  int         cycle_count = 0;
  bit         idle_on = 1'b1;
  logic [7:0] pop_pat = 8'hFF;
  logic [5:0] pop_age = 6'd0;

  // Number of magic characters actually checked
  function automatic int magic_count();
    if (reg_magic_len == 4'd0) return 1;
    if (reg_magic_len > LSE_MAGIC_MAX) return LSE_MAGIC_MAX;
    return int'(reg_magic_len);
  endfunction

  // Advance the decoder by one image byte; return 1 when it yields a result
  function automatic bit decode_byte(input logic [7:0] pix, input logic sof,
                                     output result_t res);
    int          need;
    logic [31:0] word;
    res = '0;
    if (sof) begin
      dec_phase = PH_HEADER;
      dec_hdr_seen = 8'd0;
      dec_bit_cnt = 5'd0;
      dec_shift = 32'd0;
      dec_magic_at = 3'd0;
      dec_magic_bad = 1'b0;
      dec_left = 32'd0;
    end
    if (dec_phase == PH_IDLE) return 1'b0;
    if (dec_phase == PH_HEADER) begin
      if (dec_hdr_seen < reg_header) begin
        dec_hdr_seen = dec_hdr_seen + 8'd1;
        return 1'b0;
      end
      dec_phase = PH_MAGIC;
      dec_bit_cnt = 5'd0;
      dec_shift = 32'd0;
    end
    need = (dec_phase == PH_EXTLEN || dec_phase == PH_DATALEN) ? 32 : 8;
    dec_shift = {dec_shift[30:0], pix[0]};
    if (int'(dec_bit_cnt) + 1 < need) begin
      dec_bit_cnt = dec_bit_cnt + 5'd1;
      return 1'b0;
    end
    word = dec_shift;
    dec_bit_cnt = 5'd0;
    dec_shift = 32'd0;
    case (dec_phase)
      PH_MAGIC: begin
        if (word[7:0] != reg_magic[int'(dec_magic_at) * 8 +: 8]) dec_magic_bad = 1'b1;
        if (int'(dec_magic_at) + 1 >= magic_count()) begin
          dec_magic_at = 3'd0;
          if (dec_magic_bad) begin
            dec_phase = PH_IDLE;
            res.out_kind = KIND_BADMAGIC;
            res.out_last = 1'b1;
            return 1'b1;
          end
          dec_phase = PH_EXTLEN;
        end else begin
          dec_magic_at = dec_magic_at + 3'd1;
        end
        return 1'b0;
      end
      PH_EXTLEN: begin
        if (word > 32'(reg_ext_limit)) begin
          dec_phase = PH_IDLE;
          res.out_kind = KIND_EXTLONG;
          res.out_last = 1'b1;
          return 1'b1;
        end
        dec_left = word;
        dec_phase = (word == 32'd0) ? PH_DATALEN : PH_EXT;
        return 1'b0;
      end
      PH_EXT: begin
        dec_left = dec_left - 32'd1;
        if (dec_left == 32'd0) dec_phase = PH_DATALEN;
        res.out_byte = word[7:0];
        res.out_kind = KIND_EXT;
        return 1'b1;
      end
      PH_DATALEN: begin
        if (word == 32'd0) begin
          dec_phase = PH_IDLE;
          res.out_kind = KIND_EMPTY;
          res.out_last = 1'b1;
          return 1'b1;
        end
        dec_left = word;
        dec_phase = PH_DATA;
        return 1'b0;
      end
      PH_DATA: begin
        dec_left = dec_left - 32'd1;
        res.out_byte = word[7:0];
        res.out_kind = KIND_DATA;
        if (dec_left == 32'd0) begin
          dec_phase = PH_IDLE;
          res.out_last = 1'b1;
        end
        return 1'b1;
      end
      default: begin
        dec_phase = PH_IDLE;
        return 1'b0;
      end
    endcase
  endfunction

  // Print one mismatch line (up to a cap) and count it
  task automatic report_mismatch(input string what, input int unsigned want,
                                 input int unsigned got);
    if (err_count < MAX_PRINTS)
      $display("%0t: mismatch on %s: expected 0x%0h, got 0x%0h", $time, what, want, got);
    err_count++;
  endtask

  // Result side: check each popped request against the oldest decoded result
  always @(posedge clk) begin
    result_t want;
    if (!rst && pop && !empty) begin
      if (decoded_q.size() == 0) begin
        report_mismatch("out_byte with no result due", 0, out_byte);
      end else begin
        want = decoded_q.pop_front();
        if (out_byte !== want.out_byte) report_mismatch("out_byte", want.out_byte, out_byte);
        if (out_kind !== want.out_kind) report_mismatch("out_kind", want.out_kind, out_kind);
        if (out_last !== want.out_last) report_mismatch("out_last", want.out_last, out_last);
      end
    end
    // Rotate the stall pattern; pick a new one each time the six-bit age counter wraps
    pop_age <= pop_age + 6'd1;
    if (pop_age == 6'd0)
      pop_pat <= ($urandom_range(0, 3) == 0) ? 8'hFF : (8'($urandom) | 8'h01);
    else
      pop_pat <= {pop_pat[0], pop_pat[7:1]};
    pop <= pop_pat[0];
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("lsb_stego_payload_extractor_tb: errors");
      $finish;
    end
  end

  // Offer one image byte and hold it until the block takes it
  task automatic send_byte(input logic [7:0] b, input logic sof);
    result_t r;
    push <= 1'b1;
    pixel_byte <= b;
    start_of_file <= sof;
    do @(posedge clk); while (full);
    if (decode_byte(b, sof, r)) begin
      decoded_q.push_back(r);
      results_due++;
    end
  endtask

  // Stream the built image, in bursts with gaps when idle_on is set; flag the first byte if asked
  task automatic feed(input logic sof_first, input bit counted);
    int burst;
    int gap;
    burst = $urandom_range(1, 12);
    for (int i = 0; i < img_q.size(); i++) begin
      if (idle_on && burst <= 0) begin
        push <= 1'b0;
        gap = $urandom_range(1, 5);
        repeat (gap) @(posedge clk);
        burst = $urandom_range(1, 16);
      end else if ($urandom_range(0, 299) == 0) begin
        // hold off until every due result has been taken
        push <= 1'b0;
        while (decoded_q.size() != 0) @(posedge clk);
        @(posedge clk);
      end
      send_byte(img_q[i], sof_first && i == 0);
      burst--;
      if (counted) items_sent++;
    end
    img_q.delete();
  endtask

  // Stop sending and wait for every due result, then let the pipeline settle
  task automatic drain();
    push <= 1'b0;
    while (decoded_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write all four registers while idle; narrow registers get junk in upper bits
  task automatic set_regs(input logic [7:0] hdr, input logic [3:0] mlen,
                          input logic [63:0] chars, input logic [7:0] lim);
    logic [63:0] junk;
    junk = {$urandom, $urandom};
    drain();
    cfg_we <= 1'b1;
    cfg_index <= CFG_HEADER_BYTES;
    cfg_data <= {junk[63:8], hdr};
    @(posedge clk);
    cfg_index <= CFG_MAGIC_LEN;
    cfg_data <= {junk[63:4], mlen};
    @(posedge clk);
    cfg_index <= CFG_MAGIC_CHARS;
    cfg_data <= chars;
    @(posedge clk);
    cfg_index <= CFG_EXT_LIMIT;
    cfg_data <= {junk[63:8], lim};
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    reg_header = hdr;
    reg_magic_len = mlen;
    reg_magic = chars;
    reg_ext_limit = lim;
  endtask

  // Append n hidden bits, most significant first, with random upper byte bits
  function automatic void add_bits(input logic [31:0] v, input int n);
    logic [6:0] pad;
    for (int i = n - 1; i >= 0; i--) begin
      pad = 7'($urandom);
      img_q.push_back({pad, v[i]});
    end
  endfunction

  // Flip one random bit of one checked magic character
  function automatic logic [63:0] spoil(input logic [63:0] chars, input int nm);
    int k;
    int b;
    k = $urandom_range(0, nm - 1);
    b = $urandom_range(0, 7);
    return chars ^ (64'd1 << (8 * k + b));
  endfunction

  // Build one image from the current registers, optionally cut short, and send it
  task automatic run_image(input logic sof, input logic [31:0] ext_len,
                           input logic [31:0] pay_len, input bit bad_magic, input int keep);
    logic [63:0] chars;
    int          nm;
    int          n;
    nm = magic_count();
    chars = bad_magic ? spoil(reg_magic, nm) : reg_magic;
    for (int i = 0; i < int'(reg_header); i++) img_q.push_back(8'($urandom));
    for (int k = 0; k < nm; k++) add_bits(32'(chars[8 * k +: 8]), 8);
    add_bits(ext_len, 32);
    n = (ext_len > 32'(reg_ext_limit)) ? 0 : int'(ext_len);
    for (int i = 0; i < n; i++) add_bits($urandom, 8);
    add_bits(pay_len, 32);
    n = (pay_len > PAYLOAD_CAP) ? PAYLOAD_CAP : int'(pay_len);
    for (int i = 0; i < n; i++) add_bits($urandom, 8);
    if (keep > 0)
      while (img_q.size() > keep) void'(img_q.pop_back());
    feed(sof, 1'b1);
  endtask

  // Bytes sent with no start flag after a terminal result; the block drops them
  task automatic send_noise(input int n);
    for (int i = 0; i < n; i++) img_q.push_back(8'($urandom));
    feed(1'b0, 1'b0);
  endtask

  // Reset defaults, parse starting without any start flag
  task automatic test_no_start_flag();
    run_image(1'b0, 32'd1, 32'd1, 1'b0, 0);
  endtask

  // Header skip of zero and of the largest count; the long header ends on a limit error
  task automatic test_header_extremes();
    set_regs(8'd0, 4'd1, 64'hA5, 8'd16);
    run_image(1'b1, 32'd0, 32'd1, 1'b0, 0);
    set_regs(8'd255, 4'd2, 64'h3C_C3, 8'd0);
    // header, two magic characters and the extension length
    run_image(1'b1, 32'd1, 32'd1, 1'b0, 303);
  endtask

  // Magic length clamping, mismatch, empty payload, idle afterwards
  task automatic test_magic_checks();
    set_regs(8'd2, 4'd0, 64'hFF, 8'd16);
    run_image(1'b1, 32'd0, 32'd0, 1'b0, 0);
    run_image(1'b1, 32'd1, 32'd1, 1'b1, 10);
    // eight characters are checked; cut each image after its last result
    set_regs(8'd1, 4'd15, {$urandom, $urandom}, 8'd3);
    run_image(1'b1, 32'd3, 32'd1, 1'b0, 121);
    run_image(1'b1, 32'd1, 32'd1, 1'b1, 65);
    send_noise(8);
  endtask

  // Extension length over the widest limit and huge counts
  task automatic test_extension_lengths();
    set_regs(8'd0, 4'd1, 64'h5A, 8'd255);
    run_image(1'b1, 32'd256, 32'd1, 1'b0, 40);
    run_image(1'b1, 32'hFFFF_FFFF, 32'd1, 1'b0, 40);
    send_noise(4);
  endtask

  // Payload length: huge counts cut short, restarts mid-image
  task automatic test_payload_lengths();
    set_regs(8'd0, 4'd1, {$urandom, $urandom}, 8'd4);
    run_image(1'b1, 32'd0, 32'hFFFF_FFFF, 1'b0, 96);
    run_image(1'b1, 32'd2, 32'd5, 1'b0, 30);
    run_image(1'b1, 32'd1, 32'd2, 1'b0, 2);
    run_image(1'b1, 32'd1, 32'd2, 1'b0, 0);
  endtask

  // Random images over random register settings
  task automatic test_random_images();
    int start_items;
    int start_results;
    int nimg;
    int lim;
    int pick;
    logic [31:0] ext_len;
    start_items = items_sent;
    start_results = results_due;
    nimg = 0;
    while ((items_sent - start_items < RANDOM_ITEMS ||
            results_due - start_results < RANDOM_RESULTS) && nimg < 500) begin
      if (nimg % 4 == 0)
        set_regs(($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'($urandom_range(0, 6)),
                 4'($urandom_range(0, 15)), {$urandom, $urandom},
                 ($urandom_range(0, 4) == 0) ? 8'd255 : 8'($urandom_range(0, 6)));
      idle_on = ($urandom_range(0, 3) != 0);
      lim = (reg_ext_limit < 8'd4) ? int'(reg_ext_limit) : 4;
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        run_image(1'b1, $urandom_range(0, lim), $urandom_range(1, 6), 1'b0, 0);
        if ($urandom_range(0, 4) == 0) send_noise($urandom_range(1, 6));
      end else if (pick < 70) begin
        run_image(1'b1, $urandom_range(0, lim), $urandom_range(1, 6), 1'b1, 0);
      end else if (pick < 78) begin
        if ($urandom_range(0, 3) == 0) ext_len = 32'hFFFF_FFFF - $urandom_range(0, 3);
        else ext_len = 32'(reg_ext_limit) + 32'd1 + $urandom_range(0, 3);
        run_image(1'b1, ext_len, $urandom_range(1, 6), 1'b0, 0);
      end else if (pick < 86) begin
        run_image(1'b1, $urandom_range(0, lim), 32'd0, 1'b0, 0);
      end else begin
        run_image(1'b1, $urandom_range(0, lim), $urandom_range(1, 6), 1'b0,
                  $urandom_range(1, 60));
      end
      nimg++;
    end
    idle_on = 1'b1;
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    test_no_start_flag();
    test_header_extremes();
    test_magic_checks();
    test_extension_lengths();
    test_payload_lengths();
    test_random_images();
    drain();
    if (err_count == 0)
      $display("lsb_stego_payload_extractor_tb: clean");
    else
      $display("lsb_stego_payload_extractor_tb: errors");
    $finish;
  end

endmodule
